// ----- src/rfvb_pkg.sv -----
// Shared types and constants for the radial falloff vector brush.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package rfvb_pkg;

  localparam int MAP_SIZE       = 1024;
  localparam int COMPONENT_BITS = 16;
  localparam int FALLOFF_SCALE  = 1000;

  localparam int COORD_W = 10;                  // pixel and center coordinates
  localparam int RAD_W   = 10;                  // brush radius
  localparam int SCALE_W = $clog2(FALLOFF_SCALE + 1);
  localparam int D_W     = 2 * COORD_W + 1;     // squared distance
  localparam int RR_W    = 2 * RAD_W;           // squared radius

  // square root: in-brush distances stay below radius squared
  localparam int SQ_W        = RR_W;
  localparam int ROOT_W      = RAD_W;
  localparam int REM_W       = ROOT_W + 2;
  localparam int SQRT_STEPS  = 2;
  localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

  // falloff divider: quotient never exceeds the scale
  localparam int Q_W        = SCALE_W;
  localparam int NUM_W      = ROOT_W + SCALE_W;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = Q_W / DIV_STEPS;

  // push * gain / scale through a reciprocal multiply
  localparam int PROD_W  = COMPONENT_BITS + SCALE_W;
  localparam int RECIP_K = PROD_W + SCALE_W;
  localparam int RECIP_W = RECIP_K - SCALE_W + 1;
  localparam longint unsigned RECIP_M =
      ((64'd1 << RECIP_K) + FALLOFF_SCALE - 1) / FALLOFF_SCALE;

  localparam int MAGSQ_W = 2 * COMPONENT_BITS;
  localparam int MAG_W   = MAGSQ_W + 1;

  localparam int CFG_DATA_W = (COMPONENT_BITS > COORD_W) ? COMPONENT_BITS : COORD_W;

  typedef enum logic [2:0] {
    CFG_CENTER_X     = 3'd0,
    CFG_CENTER_Y     = 3'd1,
    CFG_PUSH_X       = 3'd2,
    CFG_PUSH_Y       = 3'd3,
    CFG_BRUSH_RADIUS = 3'd4
  } rfvb_cfg_idx_t;

  typedef struct packed {
    logic        [COORD_W-1:0]        pixel_x;
    logic        [COORD_W-1:0]        pixel_y;
    logic signed [COMPONENT_BITS-1:0] current_x;
    logic signed [COMPONENT_BITS-1:0] current_y;
  } rfvb_in_t;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] result_x;
    logic signed [COMPONENT_BITS-1:0] result_y;
    logic                             replaced;
  } rfvb_out_t;

  // per-pixel context carried alongside the arithmetic units
  typedef struct packed {
    logic                             hit;
    logic signed [COMPONENT_BITS-1:0] cur_x;
    logic signed [COMPONENT_BITS-1:0] cur_y;
    logic        [MAG_W-1:0]          cmag;
  } rfvb_tag_t;

endpackage

// ----- src/radial_falloff_vector_brush.sv -----
// Top level of the radial falloff vector brush: config registers and pixel pipeline.
// Depends on rfvb_pkg, rfvb_sqrt and rfvb_div.
//
// Usage:
//  - Pixel channel: drive in_data and raise start; a pixel transfers at each
//    rising edge with start high and busy low. busy is low whenever rst_n is
//    high, so one pixel can enter every cycle.
//  - Result channel: out_valid strobes for one cycle with out_data; the
//    receiver takes it at that edge and cannot hold it off.
//  - Throughput is one pixel per cycle. The pipeline depth comes from the
//    five-stage square root, the five-stage falloff divider and the
//    reciprocal multiply that divides push*gain by 1000.
//  - Config: cfg_index selects center_x, center_y, push_x, push_y or
//    brush_radius; a write transfers when cfg_valid and cfg_ready are high.
//    Indexes beyond the list are ignored. Write only while no pixel is in
//    flight.
//  - Reset (synchronous, active low) clears the config and valid registers
//    to zero and empties the pipeline; a zero radius leaves every pixel unchanged.
`timescale 1ns / 1ps

module radial_falloff_vector_brush import rfvb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  rfvb_in_t              in_data,
  output logic                  out_valid,
  output rfvb_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  rfvb_cfg_idx_t         cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LATENCY = 3 + (SQRT_STAGES + 1) + 1 + DIV_STAGES + 4;

  // ---------------------------------------------------------------- config
  logic        [COORD_W-1:0]        center_x_r;
  logic        [COORD_W-1:0]        center_y_r;
  logic signed [COMPONENT_BITS-1:0] push_x_r;
  logic signed [COMPONENT_BITS-1:0] push_y_r;
  logic        [RAD_W-1:0]          radius_r;
  logic        [RR_W-1:0]           rr_r;

  assign cfg_ready = rst_n;
  assign busy      = ~rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      push_x_r   <= '0;
      push_y_r   <= '0;
      radius_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CENTER_X:     center_x_r <= cfg_data[COORD_W-1:0];
        CFG_CENTER_Y:     center_y_r <= cfg_data[COORD_W-1:0];
        CFG_PUSH_X:       push_x_r   <= cfg_data[COMPONENT_BITS-1:0];
        CFG_PUSH_Y:       push_y_r   <= cfg_data[COMPONENT_BITS-1:0];
        CFG_BRUSH_RADIUS: radius_r   <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // radius squared is registered from the radius register
  always_ff @(posedge clk) begin
    rr_r <= radius_r * radius_r;
  end

  // ------------------------------------------------ stage 1: coordinate deltas
  logic                             s1_vld_r;
  logic        [COORD_W-1:0]        s1_dx_r, s1_dy_r;
  logic                             s1_on_map_r;
  logic signed [COMPONENT_BITS-1:0] s1_cur_x_r, s1_cur_y_r;
  logic        [COORD_W-1:0]        s1_dx_nxt, s1_dy_nxt;
  logic                             s1_on_map_nxt;

  always_comb begin
    s1_dx_nxt = (center_x_r > in_data.pixel_x) ? center_x_r - in_data.pixel_x
                                               : in_data.pixel_x - center_x_r;
    s1_dy_nxt = (center_y_r > in_data.pixel_y) ? center_y_r - in_data.pixel_y
                                               : in_data.pixel_y - center_y_r;
    s1_on_map_nxt = (32'(in_data.pixel_x) < MAP_SIZE) && (32'(in_data.pixel_y) < MAP_SIZE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
    s1_dx_r     <= s1_dx_nxt;
    s1_dy_r     <= s1_dy_nxt;
    s1_on_map_r <= s1_on_map_nxt;
    s1_cur_x_r  <= in_data.current_x;
    s1_cur_y_r  <= in_data.current_y;
  end

  // ------------------------------------------------ stage 2: squares
  logic                             s2_vld_r;
  logic        [D_W-1:0]            s2_d_r;
  logic                             s2_on_map_r;
  logic signed [COMPONENT_BITS-1:0] s2_cur_x_r, s2_cur_y_r;
  logic        [MAGSQ_W-1:0]        s2_cxsq_r, s2_cysq_r;
  logic        [2*COORD_W-1:0]      s2_dxsq, s2_dysq;
  logic        [MAGSQ_W-1:0]        s2_cxsq_nxt, s2_cysq_nxt;

  always_comb begin
    s2_dxsq     = s1_dx_r * s1_dx_r;
    s2_dysq     = s1_dy_r * s1_dy_r;
    s2_cxsq_nxt = MAGSQ_W'(s1_cur_x_r * s1_cur_x_r);
    s2_cysq_nxt = MAGSQ_W'(s1_cur_y_r * s1_cur_y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_d_r      <= {1'b0, s2_dxsq} + {1'b0, s2_dysq};
    s2_on_map_r <= s1_on_map_r;
    s2_cur_x_r  <= s1_cur_x_r;
    s2_cur_y_r  <= s1_cur_y_r;
    s2_cxsq_r   <= s2_cxsq_nxt;
    s2_cysq_r   <= s2_cysq_nxt;
  end

  // ------------------------------------------------ stage 3: inside-brush test
  logic              s3_vld_r;
  rfvb_tag_t         s3_tag_r;
  logic [SQ_W-1:0]   s3_d_r;
  rfvb_tag_t         s3_tag_nxt;

  always_comb begin
    s3_tag_nxt.hit   = s2_on_map_r && (s2_d_r < {1'b0, rr_r});
    s3_tag_nxt.cur_x = s2_cur_x_r;
    s3_tag_nxt.cur_y = s2_cur_y_r;
    s3_tag_nxt.cmag  = {1'b0, s2_cxsq_r} + {1'b0, s2_cysq_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_tag_r <= s3_tag_nxt;
    // outside the brush the root is never used, so the top bit may drop
    s3_d_r   <= s2_d_r[SQ_W-1:0];
  end

  // ------------------------------------------------ rounded square root
  logic              sq_vld;
  rfvb_tag_t         sq_tag;
  logic [ROOT_W-1:0] sq_dist;

  rfvb_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s3_vld_r),
    .tag_i  (s3_tag_r),
    .d_i    (s3_d_r),
    .vld_o  (sq_vld),
    .tag_o  (sq_tag),
    .dist_o (sq_dist)
  );

  // ------------------------------------------------ stage 4: scale by 1000
  logic             s4_vld_r;
  rfvb_tag_t        s4_tag_r;
  logic [NUM_W-1:0] s4_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= sq_vld;
    end
    s4_tag_r <= sq_tag;
    s4_num_r <= sq_dist * SCALE_W'(FALLOFF_SCALE);
  end

  // ------------------------------------------------ falloff = num / radius
  logic           dv_vld;
  rfvb_tag_t      dv_tag;
  logic [Q_W-1:0] dv_quo;

  rfvb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (s4_vld_r),
    .tag_i (s4_tag_r),
    .num_i (s4_num_r),
    .den_i (radius_r),
    .vld_o (dv_vld),
    .tag_o (dv_tag),
    .quo_o (dv_quo)
  );

  // ------------------------------------------------ stage 5: |push| * gain
  logic              s5_vld_r;
  rfvb_tag_t         s5_tag_r;
  logic [PROD_W-1:0] s5_prod_x_r, s5_prod_y_r;
  logic [SCALE_W-1:0]        s5_gain;
  logic [COMPONENT_BITS-1:0] s5_pabs_x, s5_pabs_y;

  always_comb begin
    s5_gain   = SCALE_W'(FALLOFF_SCALE) - dv_quo;
    s5_pabs_x = push_x_r[COMPONENT_BITS-1] ? ~push_x_r + 1'b1 : push_x_r;
    s5_pabs_y = push_y_r[COMPONENT_BITS-1] ? ~push_y_r + 1'b1 : push_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= dv_vld;
    end
    s5_tag_r    <= dv_tag;
    s5_prod_x_r <= s5_pabs_x * s5_gain;
    s5_prod_y_r <= s5_pabs_y * s5_gain;
  end

  // ------------------------------------------------ stage 6: divide by 1000
  // floor(p / 1000) = (p * ceil(2^K / 1000)) >> K for every p below 2^PROD_W
  logic                        s6_vld_r;
  rfvb_tag_t                   s6_tag_r;
  logic [COMPONENT_BITS-1:0]   s6_q_x_r, s6_q_y_r;
  logic [PROD_W+RECIP_W-1:0]   s6_mx, s6_my;

  always_comb begin
    s6_mx = s5_prod_x_r * RECIP_W'(RECIP_M);
    s6_my = s5_prod_y_r * RECIP_W'(RECIP_M);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
    s6_tag_r <= s5_tag_r;
    s6_q_x_r <= s6_mx[RECIP_K +: COMPONENT_BITS];
    s6_q_y_r <= s6_my[RECIP_K +: COMPONENT_BITS];
  end

  // ------------------------------------------------ stage 7: sign and target squares
  logic                             s7_vld_r;
  rfvb_tag_t                        s7_tag_r;
  logic signed [COMPONENT_BITS-1:0] s7_tx_r, s7_ty_r;
  logic        [MAGSQ_W-1:0]        s7_txsq_r, s7_tysq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else begin
      s7_vld_r <= s6_vld_r;
    end
    s7_tag_r  <= s6_tag_r;
    s7_tx_r   <= push_x_r[COMPONENT_BITS-1] ? ~s6_q_x_r + 1'b1 : s6_q_x_r;
    s7_ty_r   <= push_y_r[COMPONENT_BITS-1] ? ~s6_q_y_r + 1'b1 : s6_q_y_r;
    s7_txsq_r <= s6_q_x_r * s6_q_x_r;
    s7_tysq_r <= s6_q_y_r * s6_q_y_r;
  end

  // ------------------------------------------------ stage 8: magnitude compare
  logic       [MAG_W-1:0] s8_tmag;
  logic                   s8_rep;
  logic                   out_vld_r;
  rfvb_out_t              out_data_r;
  rfvb_out_t              out_data_nxt;

  always_comb begin
    s8_tmag = {1'b0, s7_txsq_r} + {1'b0, s7_tysq_r};
    s8_rep  = s7_tag_r.hit && (s8_tmag > s7_tag_r.cmag);
    out_data_nxt.result_x = s8_rep ? s7_tx_r : s7_tag_r.cur_x;
    out_data_nxt.result_y = s8_rep ? s7_ty_r : s7_tag_r.cur_y;
    out_data_nxt.replaced = s8_rep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= s7_vld_r;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // ------------------------------------------------ checks
  a_result_latency: assert property (@(posedge clk)
    out_valid |-> $past(start && rst_n, LATENCY))
    else $error("result strobe without a pixel transfer");

  a_hit_needs_radius: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r && s3_tag_r.hit |-> $past(radius_r, 2) != '0)
    else $error("pixel inside a zero-radius brush");

  a_replace_from_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.replaced |-> $past(s7_vld_r && s7_tag_r.hit))
    else $error("vector replaced outside the brush");

  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.replaced |->
      out_data.result_x == $past(s7_tag_r.cur_x) && out_data.result_y == $past(s7_tag_r.cur_y))
    else $error("unreplaced vector altered");

endmodule

// ----- src/rfvb_sqrt.sv -----
// Pipelined rounded integer square root, two root bits per stage.
// Depends on rfvb_pkg (widths, stage count, context tag type).
`timescale 1ns / 1ps

module rfvb_sqrt import rfvb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  rfvb_tag_t         tag_i,
  input  logic [SQ_W-1:0]   d_i,
  output logic              vld_o,
  output rfvb_tag_t         tag_o,
  output logic [ROOT_W-1:0] dist_o
);

  logic              vld_r  [SQRT_STAGES];
  rfvb_tag_t         tag_r  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_r [SQRT_STAGES];
  logic [REM_W-1:0]  rem_r  [SQRT_STAGES];
  logic [SQ_W-1:0]   dsh_r  [SQRT_STAGES];

  logic              out_vld_r;
  rfvb_tag_t         out_tag_r;
  logic [ROOT_W-1:0] dist_r;
  logic [ROOT_W-1:0] dist_nxt;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic              vld_in;
    rfvb_tag_t         tag_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  rem_in;
    logic [SQ_W-1:0]   dsh_in;
    logic [ROOT_W-1:0] root_nxt;
    logic [REM_W-1:0]  rem_nxt;
    logic [SQ_W-1:0]   dsh_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign tag_in  = tag_i;
      assign root_in = '0;
      assign rem_in  = '0;
      assign dsh_in  = d_i;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign tag_in  = tag_r[k-1];
      assign root_in = root_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign dsh_in  = dsh_r[k-1];
    end

    // digit-by-digit: remainder = d_so_far - root^2
    always_comb begin
      logic [REM_W+1:0] acc;
      logic [REM_W+1:0] trial;
      root_nxt = root_in;
      rem_nxt  = rem_in;
      dsh_nxt  = dsh_in;
      for (int j = 0; j < SQRT_STEPS; j++) begin
        acc   = {rem_nxt, dsh_nxt[SQ_W-1 -: 2]};
        trial = {{(REM_W-ROOT_W){1'b0}}, root_nxt, 2'b01};
        if (acc >= trial) begin
          acc      = acc - trial;
          root_nxt = {root_nxt[ROOT_W-2:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[ROOT_W-2:0], 1'b0};
        end
        rem_nxt = acc[REM_W-1:0];
        dsh_nxt = {dsh_nxt[SQ_W-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
      tag_r[k]  <= tag_in;
      root_r[k] <= root_nxt;
      rem_r[k]  <= rem_nxt;
      dsh_r[k]  <= dsh_nxt;
    end
  end

  // round to nearest: remainder above root means d > s*s + s
  always_comb begin
    dist_nxt = root_r[SQRT_STAGES-1];
    if (rem_r[SQRT_STAGES-1] > {{(REM_W-ROOT_W){1'b0}}, root_r[SQRT_STAGES-1]}) begin
      dist_nxt = root_r[SQRT_STAGES-1] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[SQRT_STAGES-1];
    end
    out_tag_r <= tag_r[SQRT_STAGES-1];
    dist_r    <= dist_nxt;
  end

  assign vld_o  = out_vld_r;
  assign tag_o  = out_tag_r;
  assign dist_o = dist_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SQRT_STAGES-1] |->
      {1'b0, rem_r[SQRT_STAGES-1]} <= {{(REM_W-ROOT_W){1'b0}}, root_r[SQRT_STAGES-1], 1'b0})
    else $error("sqrt remainder exceeds twice the root");

  a_latency: assert property (@(posedge clk)
    vld_o |-> $past(vld_i && rst_n, SQRT_STAGES + 1))
    else $error("sqrt result without matching entry");

endmodule

// ----- src/rfvb_div.sv -----
// Pipelined restoring divider for the falloff ratio, two quotient bits per stage.
// Depends on rfvb_pkg (widths, stage count, context tag type).
`timescale 1ns / 1ps

module rfvb_div import rfvb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  input  rfvb_tag_t        tag_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [RAD_W-1:0] den_i,
  output logic             vld_o,
  output rfvb_tag_t        tag_o,
  output logic [Q_W-1:0]   quo_o
);

  // numerator high part starts below the divisor, so Q_W steps give the quotient
  logic             vld_r [DIV_STAGES];
  rfvb_tag_t        tag_r [DIV_STAGES];
  logic [RAD_W-1:0] rem_r [DIV_STAGES];
  logic [Q_W-1:0]   lo_r  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic             vld_in;
    rfvb_tag_t        tag_in;
    logic [RAD_W-1:0] rem_in;
    logic [Q_W-1:0]   lo_in;
    logic [RAD_W-1:0] rem_nxt;
    logic [Q_W-1:0]   lo_nxt;

    if (k == 0) begin : g_first
      assign vld_in = vld_i;
      assign tag_in = tag_i;
      assign rem_in = num_i[NUM_W-1:Q_W];
      assign lo_in  = num_i[Q_W-1:0];
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign tag_in = tag_r[k-1];
      assign rem_in = rem_r[k-1];
      assign lo_in  = lo_r[k-1];
    end

    // lo shifts numerator bits out at the top and quotient bits in at the bottom
    always_comb begin
      logic [RAD_W:0] acc;
      rem_nxt = rem_in;
      lo_nxt  = lo_in;
      for (int j = 0; j < DIV_STEPS; j++) begin
        acc    = {rem_nxt, lo_nxt[Q_W-1]};
        lo_nxt = {lo_nxt[Q_W-2:0], 1'b0};
        if (acc >= {1'b0, den_i}) begin
          acc       = acc - {1'b0, den_i};
          lo_nxt[0] = 1'b1;
        end
        rem_nxt = acc[RAD_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
      tag_r[k] <= tag_in;
      rem_r[k] <= rem_nxt;
      lo_r[k]  <= lo_nxt;
    end
  end

  assign vld_o = vld_r[DIV_STAGES-1];
  assign tag_o = tag_r[DIV_STAGES-1];
  assign quo_o = lo_r[DIV_STAGES-1];

endmodule
